// ===== sv/log_event_backoff_table_macros.svh =====
// Assertion macros shared by the checker.
`ifndef LOG_EVENT_BACKOFF_TABLE_MACROS_SVH
`define LOG_EVENT_BACKOFF_TABLE_MACROS_SVH
// Property holds at every clock outside reset.
`define LEBT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

// ===== sv/lebt_pkg.sv =====
`default_nettype none
package lebt_pkg;
  localparam int Entries = 16;
  localparam int KeyBits = 64;
  localparam int SlotW = $clog2(Entries);
  localparam int PerW = 20;
  localparam logic [PerW-1:0] PeriodMax = {PerW{1'b1}};
  localparam logic CmdEvent = 1'b0;
  localparam logic CmdTick = 1'b1;
  localparam logic [1:0] RegInit = 2'd0;
  localparam logic [1:0] RegMult = 2'd1;
  localparam logic [1:0] RegLimit = 2'd2;
  localparam int QDepth = 2;

  typedef struct packed {
    logic cmd;
    logic [KeyBits-1:0] key;
  } req_t;

  function automatic logic [PerW-1:0] grow(input logic [PerW-1:0] p,
      input logic [15:0] lim, input logic [4:0] mul);
    logic [PerW+4:0] n;
    begin
      n = p * mul;
      if (p >= {4'd0, lim}) grow = p;
      else if (n > {5'd0, PeriodMax}) grow = PeriodMax;
      else grow = n[PerW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== sv/lebt_front.sv =====
`default_nettype none
module lebt_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire logic cmd_i,
  input  wire logic [63:0] event_key_i,
  output logic q_valid_o,
  output lebt_pkg::req_t q_req_o,
  input  wire logic q_pop_i
);
  import lebt_pkg::*;
  req_t mem_q [QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, drop;
  // drop zero-key events at the front
  assign drop = (cmd_i == CmdEvent) && (event_key_i[KeyBits-1:0] == '0);
  assign in_stall_o = (cnt_q == 2'(QDepth));
  assign push = in_valid_i && !in_stall_o && !drop;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = mem_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= '{cmd: cmd_i, key: event_key_i[KeyBits-1:0]};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== sv/lebt_back.sv =====
`default_nettype none
module lebt_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic q_valid_i,
  input  lebt_pkg::req_t q_req_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic [3:0] slot_o,
  output logic [63:0] log_key_o,
  output logic last_o
);
  import lebt_pkg::*;
  localparam logic SIdle = 1'b0, SScan = 1'b1;
  logic st_q, st_d;
  logic [15:0] init_q, lim_q;
  logic [4:0] mul_q;
  logic [Entries-1:0] val_q, hit_q;
  logic [KeyBits-1:0] key_q [Entries];
  logic [PerW-1:0] per_q [Entries];
  logic [PerW-1:0] cd_q [Entries];
  logic [SlotW-1:0] idx_q;
  logic cmd_q, found_q, free_vld_q;
  logic [SlotW-1:0] free_idx_q;
  logic [KeyBits-1:0] ekey_q;
  logic [Entries-1:0] due, due_hi;
  logic [PerW-1:0] gp, gp_init;
  logic at_end, scan, cur_val, cur_match, cur_exp;
  logic tick_emit, ev_emit, emit, out_busy, step;
  logic [SlotW-1:0] new_slot;

  assign at_end = (idx_q == SlotW'(Entries-1));
  assign scan = (st_q == SScan);
  assign cur_val = val_q[idx_q];
  assign cur_match = cur_val && (key_q[idx_q] == ekey_q);
  assign cur_exp = cur_val && (cd_q[idx_q] <= PerW'(1));
  assign gp = grow(per_q[idx_q], lim_q, mul_q);
  assign gp_init = grow({4'd0, init_q}, lim_q, mul_q);
  assign tick_emit = (cmd_q == CmdTick) && cur_exp && hit_q[idx_q];
  // no match anywhere: take the highest free slot and log at once
  assign ev_emit = (cmd_q == CmdEvent) && at_end && !found_q && !cur_match &&
                   (!cur_val || free_vld_q);
  assign new_slot = cur_val ? free_idx_q : idx_q;
  assign emit = scan && (tick_emit || ev_emit);
  assign out_busy = out_valid_o && out_stall_i;
  // one slot per cycle; hold while a new result meets a stalled output
  assign step = scan && !(emit && out_busy);
  assign q_pop_o = (st_q == SIdle) && q_valid_i;

  // entries that log on this tick; the last one above the scan point closes it
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      due[i] = val_q[i] && hit_q[i] && (cd_q[i] <= PerW'(1));
    end
  end
  assign due_hi = due >> idx_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle: if (q_valid_i) st_d = SScan;
      SScan: if (step && at_end) st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; init_q <= 16'd60; mul_q <= 5'd4; lim_q <= 16'd43200;
      val_q <= '0; hit_q <= '0; idx_q <= '0; cmd_q <= CmdEvent; ekey_q <= '0;
      found_q <= 1'b0; free_vld_q <= 1'b0; free_idx_q <= '0;
      out_valid_o <= 1'b0; slot_o <= '0; log_key_o <= '0; last_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegInit: init_q <= cfg_data_i;
          RegMult: mul_q <= cfg_data_i[4:0];
          RegLimit: lim_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (q_pop_o) begin
        cmd_q <= q_req_i.cmd; ekey_q <= q_req_i.key; idx_q <= '0;
        found_q <= 1'b0; free_vld_q <= 1'b0;
      end
      if (step) begin
        idx_q <= idx_q + SlotW'(1);
        if (cmd_q == CmdEvent) begin
          if (ev_emit) begin
            val_q[new_slot] <= 1'b1; hit_q[new_slot] <= 1'b0;
          end else if (cur_match) begin
            hit_q[idx_q] <= 1'b1; found_q <= 1'b1;
          end
          if (!cur_val) begin
            free_vld_q <= 1'b1; free_idx_q <= idx_q;
          end
        end else if (cur_exp) begin
          // expired: a hit entry logs and stays, an idle one is freed
          if (hit_q[idx_q]) hit_q[idx_q] <= 1'b0;
          else val_q[idx_q] <= 1'b0;
        end
      end
      if (emit && step) begin
        out_valid_o <= 1'b1;
        slot_o <= 4'(tick_emit ? idx_q : new_slot);
        log_key_o <= tick_emit ? key_q[idx_q] : ekey_q;
        last_o <= ev_emit || (due_hi[Entries-1:1] == '0);
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      if (cmd_q == CmdEvent) begin
        if (ev_emit) begin
          key_q[new_slot] <= ekey_q;
          per_q[new_slot] <= gp_init;
          cd_q[new_slot] <= gp_init;
        end
      end else if (cur_val) begin
        if (!cur_exp) cd_q[idx_q] <= cd_q[idx_q] - PerW'(1);
        else if (hit_q[idx_q]) begin
          per_q[idx_q] <= gp;
          cd_q[idx_q] <= gp;
        end else cd_q[idx_q] <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/log_event_backoff_table.sv =====
`default_nettype none
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o  cmd_i, event_key_i
// out       output     out_valid_o/out_stall_i slot_o, log_key_o, last_o
// cfg       input      cfg_we_i               cfg_idx_i, cfg_data_i
// A request waits in the two-entry front queue; the back pops it only when idle, then
// scans the table one slot per cycle except while held by a stalled output as below,
// and takes the next request only after the scan of the last slot.
// Each log goes out through the output register; a new log that meets a stalled
// output holds the scan for as long as the stall lasts, and a full queue stalls the input.
// Reset clears valid and hit marks and loads the register defaults.
module log_event_backoff_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire logic cmd_i,
  input  wire logic [63:0] event_key_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic [3:0] slot_o,
  output logic [63:0] log_key_o,
  output logic last_o
);
  import lebt_pkg::*;
  logic q_valid, q_pop;
  req_t q_req;
  lebt_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i,
    .event_key_i, .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop));
  lebt_back u_back (.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop), .out_valid_o,
    .out_stall_i, .slot_o, .log_key_o, .last_o);
endmodule
`default_nettype wire

// ===== sv/lebt_checker.sv =====
`default_nettype none
`include "log_event_backoff_table_macros.svh"
module lebt_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [3:0] slot_o,
  input wire logic last_o
);
  `LEBT_ASSERT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "valid dropped")
  `LEBT_ASSERT(a_slot, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(slot_o), "slot moved")
  `LEBT_ASSERT(a_last, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(last_o), "last moved")
endmodule
bind log_event_backoff_table lebt_checker u_chk (.clk_i, .rst_ni, .out_valid_o,
  .out_stall_i, .slot_o, .last_o);
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lebt_pkg::*;

  localparam int NumRandom = 260;
  // Requests still queued or scanning after the last log: the queue, the back
  // and one more, each a full slot scan.
  localparam int DrainCycles = (QDepth + 2) * (Entries + 1);
  // Index that maps to no register.
  localparam logic [1:0] RegNone = 2'd3;

  typedef struct packed {
    logic [3:0]  slot;
    logic [63:0] key;
    logic        last;
  } log_t;

  // One row of the directed table. A typed-in result is checked directly
  // against the predictor, so a wrong prediction shows up as well.
  typedef struct packed {
    logic        cmd;
    logic [63:0] key;
    logic        has_exp;
    logic [3:0]  exp_slot;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegInit;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = CmdEvent;
  logic [63:0] event_key_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] slot_o;
  logic [63:0] log_key_o;
  logic last_o;

  log_event_backoff_table u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state, mirrors the table.
  logic [15:0] cur_init, cur_limit;
  logic [4:0]  cur_mult;
  logic        tbl_valid [Entries];
  logic        tbl_hit   [Entries];
  logic [63:0] tbl_key   [Entries];
  logic [PerW-1:0] tbl_per [Entries];
  logic [PerW-1:0] tbl_cnt [Entries];

  log_t pending_logs[$];
  int   mismatches = 0;
  int   last_cnt = 0;     // logs caused by the latest request
  bit   rx_quiet = 1'b0;   // no random receiver stalls
  bit   tx_quiet = 1'b0;   // no random sender gaps
  int   rx_hold = 0;       // cycles of forced receiver hold-off

  function automatic logic [PerW-1:0] next_period(logic [PerW-1:0] p);
    logic [31:0] n;
    if (p >= {4'd0, cur_limit}) return p;
    n = p * cur_mult;
    if (n > PeriodMax) return PeriodMax;
    return n[PerW-1:0];
  endfunction

  // Work out the logs one request causes and queue them.
  task automatic predict_logs(input logic cmd, input logic [63:0] key, output int cnt);
    int free_slot;
    int first;
    free_slot = -1;
    first = pending_logs.size();
    cnt = 0;
    if (cmd == CmdEvent) begin
      if (key == 0) return;
      for (int i = 0; i < Entries; i++) begin
        if (!tbl_valid[i]) begin
          free_slot = i;
        end else if (tbl_key[i] == key) begin
          tbl_hit[i] = 1'b1;
          return;
        end
      end
      if (free_slot < 0) return;
      tbl_valid[free_slot] = 1'b1;
      tbl_key[free_slot] = key;
      tbl_hit[free_slot] = 1'b0;
      tbl_per[free_slot] = next_period({4'd0, cur_init});
      tbl_cnt[free_slot] = tbl_per[free_slot];
      pending_logs.push_back('{free_slot[3:0], key, 1'b1});
      cnt = 1;
      return;
    end
    for (int i = 0; i < Entries; i++) begin
      if (!tbl_valid[i]) continue;
      if (tbl_cnt[i] > 1) begin
        tbl_cnt[i]--;
        continue;
      end
      if (tbl_hit[i]) begin
        pending_logs.push_back('{i[3:0], tbl_key[i], 1'b0});
        cnt++;
        tbl_hit[i] = 1'b0;
        tbl_per[i] = next_period(tbl_per[i]);
        tbl_cnt[i] = tbl_per[i];
      end else begin
        tbl_valid[i] = 1'b0;
        tbl_hit[i] = 1'b0;
        tbl_cnt[i] = '0;
      end
    end
    if (cnt > 0) pending_logs[first + cnt - 1].last = 1'b1;
  endtask

  // Receiver: random stalls, a forced hold-off when asked, compare on accept.
  always @(posedge clk_i) begin
    log_t exp_log;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_logs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected log slot=%0d key=%h last=%b", slot_o, log_key_o, last_o);
        end else begin
          exp_log = pending_logs.pop_front();
          if (slot_o !== exp_log.slot || log_key_o !== exp_log.key ||
              last_o !== exp_log.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("log mismatch: exp slot=%0d key=%h last=%b got slot=%0d key=%h last=%b",
                       exp_log.slot, exp_log.key, exp_log.last, slot_o, log_key_o, last_o);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !rx_quiet && ($urandom_range(99) < 23);
      end
    end
  end

  // Write one register, then drop the write enable and mirror the value in the predictor.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegInit:  cur_init = val;
      RegMult:  cur_mult = val[4:0];
      RegLimit: cur_limit = val;
      default: ;
    endcase
  endtask

  // Offer one request and hold it until accepted; a random gap before the next request
  // or the drain takes valid down.
  task automatic send_request(input logic cmd, input logic [63:0] key);
    int cnt;
    while (!tx_quiet && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    event_key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    predict_logs(cmd, key, cnt);
    last_cnt = cnt;
  endtask

  // Wait for every expected log, then let the remaining scans finish.
  task automatic drain_logs();
    in_valid_i <= 1'b0;
    while (pending_logs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  row_t directed [] = '{
    '{CmdEvent, 64'h0, 1'b0, 4'd0},                   // zero key, ignored
    '{CmdTick,  64'h0, 1'b0, 4'd0},                   // tick on empty table
    '{CmdEvent, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd15},
    '{CmdEvent, 64'h1, 1'b1, 4'd14},
    '{CmdEvent, 64'h1, 1'b0, 4'd0},                   // hit on existing
    '{CmdEvent, 64'h8000_0000_0000_0000, 1'b1, 4'd13},
    '{CmdTick,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd0},
    '{CmdEvent, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd0}
  };

  initial begin
    int k, phase;
    logic [63:0] pool [8];
    cur_init = 16'd60;
    cur_mult = 5'd4;
    cur_limit = 16'd43200;
    for (int i = 0; i < Entries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_hit[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_per[i] = '0;
      tbl_cnt[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset settings.
    foreach (directed[r]) begin
      send_request(directed[r].cmd, directed[r].key);
      if (directed[r].has_exp && (last_cnt != 1 ||
          pending_logs[pending_logs.size() - 1].slot != directed[r].exp_slot)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: expected one log at slot %0d, got %0d logs",
                   r, directed[r].exp_slot, last_cnt);
      end
    end
    drain_logs();

    // Short periods, a large multiplier, full table and unknown register.
    write_reg(RegInit, 16'd1);
    write_reg(RegMult, 16'd16);
    write_reg(RegLimit, 16'hFFFF);
    write_reg(RegNone, 16'hABCD);
    for (int i = 0; i < 18; i++) send_request(CmdEvent, 64'h100 + i);
    for (int t = 0; t < 6; t++) begin
      for (int i = 0; i < 18; i++) send_request(CmdEvent, 64'h100 + i);
      send_request(CmdTick, '0);
    end
    drain_logs();

    // Random phases across settings, extremes included.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(RegInit, 16'd1); write_reg(RegMult, 16'd1); write_reg(RegLimit, 16'd1);
        end
        1: begin
          write_reg(RegInit, 16'd2); write_reg(RegMult, 16'd2); write_reg(RegLimit, 16'd16);
        end
        2: begin
          write_reg(RegInit, 16'hFFFF); write_reg(RegMult, 16'd16);
          write_reg(RegLimit, 16'hFFFF);
        end
        default: begin
          write_reg(RegInit, 16'd3); write_reg(RegMult, 16'd3); write_reg(RegLimit, 16'd40);
        end
      endcase
      foreach (pool[p]) pool[p] = rand_key();
      rx_quiet = (phase == 1);
      tx_quiet = (phase == 1);
      // Long receiver hold-off while requests keep flowing.
      if (phase == 3) rx_hold <= 300;
      for (int n = 0; n < NumRandom / 4; n++) begin
        k = $urandom_range(99);
        if (k < 35) send_request(CmdTick, rand_key());
        else if (k < 85) send_request(CmdEvent, pool[$urandom_range(7)]);
        else if (k < 90) send_request(CmdEvent, '0);
        else send_request(CmdEvent, rand_key());
      end
      // Sender pause until all logs are in.
      drain_logs();
    end
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;

    drain_logs();
    if (mismatches == 0 && pending_logs.size() == 0) begin
      $display("[log_event_backoff_table] OK");
    end else begin
      $display("[log_event_backoff_table] ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("[log_event_backoff_table] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/lebt_pkg.sv
sv/lebt_front.sv
sv/lebt_back.sv
sv/log_event_backoff_table.sv
sv/lebt_checker.sv
dv/testbench.sv
